[sv/assert_macros.svh]
// Assertion macros used by the datapath RTL of the block table heap allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[sv/btha_pkg.sv]
// Package of the block table heap allocator: constants, flag codes and control structs.
package btha_pkg;

    localparam int BLOCK_BYTES_DEF = 4096;
    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int FLAG_W     = 3;
    localparam int CFG_W      = 32;
    localparam int BCOUNT_W   = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [FLAG_W-1:0] FLAG_NONE  = 3'b000;
    localparam logic [FLAG_W-1:0] FLAG_TAKEN = 3'b001;
    localparam logic [FLAG_W-1:0] FLAG_FIRST = 3'b010;
    localparam logic [FLAG_W-1:0] FLAG_NEXT  = 3'b100;
    localparam logic [7:0]        FREE_MASK  = 8'h0f;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT = 1'b1;

    localparam logic [CFG_W-1:0]    BASE_RESET  = 32'h0000_0000;
    localparam logic [BCOUNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic scan_init;
        logic scan_step;
        logic mark_step;
        logic free_init;
        logic free_rd;
        logic free_wr;
        logic put;
        logic put_ok;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic mode;
        logic req_bad;
        logic blk_bad;
        logic scan_hit;
        logic scan_end;
        logic mark_last;
        logic free_more;
        logic out_busy;
    } t_stat;

endpackage

[sv/btha_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module btha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/btha_dp.sv]
// Datapath of the block table heap allocator: config, table RAM, scan and result registers.
`include "assert_macros.svh"
module btha_dp #(
    parameter int BLOCK_BYTES = btha_pkg::BLOCK_BYTES_DEF,
    parameter int TABLE_DEPTH = btha_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  btha_pkg::t_cmd                      i_cmd,
    output btha_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_we,
    input  logic [btha_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [btha_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [63:0]                         i_s_tdata,
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [31:0]                         o_m_tdata,
    output logic                                o_m_tuser
);
    import btha_pkg::*;

    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int REQ_W = 33 - BLOCK_SHIFT;
    localparam int BLK_W = 32 - BLOCK_SHIFT;
    localparam int CMP_W = (REQ_W > CNT_W) ? REQ_W : CNT_W;
    localparam logic [31:0] LOW_MASK = 32'(BLOCK_BYTES - 1);

    // configuration
    logic [CFG_W-1:0]    r_base;
    logic [BCOUNT_W-1:0] r_block_count;

    // current request
    logic             r_mode;
    logic [REQ_W-1:0] r_req;
    logic [BLK_W-1:0] r_blk;

    // clear pass, scan and run pointers
    logic [IDX_W-1:0] r_clr_idx;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;
    logic [CNT_W-1:0] r_run;
    logic [IDX_W-1:0] r_sb;
    logic [IDX_W-1:0] r_end;
    logic [IDX_W-1:0] r_ptr;

    // result register
    logic        r_out_valid;
    logic [31:0] r_out_addr;
    logic        r_out_ok;

    logic [31:0]       base_al;
    logic [CNT_W-1:0]  blocks_used;
    logic [CNT_W-1:0]  req_cnt;
    logic [32:0]       req_sum;
    logic [31:0]       free_off;
    logic [FLAG_W-1:0] ram_rdata;
    logic [FLAG_W-1:0] ram_wdata;
    logic [FLAG_W-1:0] mark_flags;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;
    logic              ram_we;
    logic              ram_re;
    logic              scan_rd;
    logic              entry_free;
    logic [CNT_W-1:0]  run_inc;
    logic              scan_hit;
    logic [IDX_W-1:0]  hit_sb;
    logic [IDX_W-1:0]  hit_end;
    logic              free_more;

    assign base_al = r_base & ~LOW_MASK;

    always_comb begin
        if (32'(r_block_count) > 32'(TABLE_DEPTH)) begin
            blocks_used = CNT_W'(TABLE_DEPTH);
        end else begin
            blocks_used = CNT_W'(r_block_count);
        end
    end

    assign req_cnt  = CNT_W'(r_req);
    assign req_sum  = {1'b0, i_s_tdata[31:0]} + 33'(BLOCK_BYTES - 1);
    assign free_off = i_s_tdata[63:32] - base_al;

    // scan: data of r_pidx arrives while r_rd_idx is read
    assign scan_rd    = i_cmd.scan_step && (r_rd_idx < blocks_used);
    assign entry_free = ((8'(ram_rdata) & FREE_MASK) == 8'h00);
    assign run_inc    = r_run + CNT_W'(1);
    assign scan_hit   = r_pv && entry_free && (run_inc == req_cnt);
    assign hit_sb     = r_pidx - IDX_W'(r_run);
    assign hit_end    = IDX_W'(CNT_W'(hit_sb) + req_cnt - CNT_W'(1));

    assign mark_flags = FLAG_TAKEN
                      | ((r_ptr == r_sb)  ? FLAG_FIRST : FLAG_NONE)
                      | ((r_ptr != r_end) ? FLAG_NEXT  : FLAG_NONE);

    assign free_more = ((ram_rdata & FLAG_NEXT) != FLAG_NONE)
                    && ((CNT_W'(r_ptr) + CNT_W'(1)) < blocks_used);

    assign ram_we    = i_cmd.clear_step || i_cmd.mark_step || i_cmd.free_wr;
    assign ram_waddr = i_cmd.clear_step ? r_clr_idx : r_ptr;
    assign ram_wdata = i_cmd.mark_step ? mark_flags : FLAG_NONE;
    assign ram_re    = scan_rd || i_cmd.free_rd;
    assign ram_raddr = i_cmd.scan_step ? r_rd_idx[IDX_W-1:0] : r_ptr;

    btha_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= BASE_RESET;
            r_block_count <= COUNT_RESET;
            r_clr_idx     <= '0;
            r_pv          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IDX_BASE:  r_base <= i_cfg_data;
                    CFG_IDX_COUNT: r_block_count <= i_cfg_data[BCOUNT_W-1:0];
                    default:       r_base <= r_base;
                endcase
            end
            if (i_cmd.clear_step) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            r_pv <= scan_rd;
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_s_tuser;
            r_req  <= REQ_W'(req_sum >> BLOCK_SHIFT);
            r_blk  <= BLK_W'(free_off >> BLOCK_SHIFT);
        end
        if (i_cmd.scan_init) begin
            r_rd_idx <= '0;
            r_run    <= '0;
        end else if (i_cmd.scan_step) begin
            if (scan_rd) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            r_pidx <= r_rd_idx[IDX_W-1:0];
            if (r_pv) begin
                r_run <= entry_free ? run_inc : '0;
            end
        end
        if (scan_hit) begin
            r_sb  <= hit_sb;
            r_end <= hit_end;
            r_ptr <= hit_sb;
        end else if (i_cmd.free_init) begin
            r_ptr <= IDX_W'(r_blk);
        end else if (i_cmd.mark_step || (i_cmd.free_wr && free_more)) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end
        if (i_cmd.put) begin
            r_out_ok <= i_cmd.put_ok;
            if (i_cmd.put_ok && (r_mode == MODE_ALLOC)) begin
                r_out_addr <= base_al + (32'(r_sb) << BLOCK_SHIFT);
            end else begin
                r_out_addr <= 32'h0;
            end
        end
    end

    always_comb begin
        o_stat.clear_last = (r_clr_idx == IDX_W'(TABLE_DEPTH - 1));
        o_stat.mode       = r_mode;
        o_stat.req_bad    = (r_req == '0) || (CMP_W'(r_req) > CMP_W'(blocks_used));
        o_stat.blk_bad    = (CMP_W'(r_blk) >= CMP_W'(blocks_used));
        o_stat.scan_hit   = scan_hit;
        o_stat.scan_end   = r_pv && !scan_hit
                         && ((CNT_W'(r_pidx) + CNT_W'(1)) == blocks_used);
        o_stat.mark_last  = (r_ptr == r_end);
        o_stat.free_more  = free_more;
        o_stat.out_busy   = r_out_valid && !i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_addr;
    assign o_m_tuser  = r_out_ok;

    `ASSERT_NEVER(a_put_when_busy, i_clk, i_rst_n, i_cmd.put && r_out_valid && !i_m_tready)
    `ASSERT_CLKD(a_mark_in_run, i_clk, i_rst_n, i_cmd.mark_step |-> (r_ptr <= r_end))
    `ASSERT_CLKD(a_free_in_use, i_clk, i_rst_n, i_cmd.free_wr |-> (CNT_W'(r_ptr) < blocks_used))
    `ASSERT_CLKD(a_hit_fits, i_clk, i_rst_n, scan_hit |-> ((32'(hit_sb) + 32'(req_cnt)) <= 32'(blocks_used)))

endmodule

[sv/btha_ctrl.sv]
// Controller state machine of the block table heap allocator.
module btha_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  btha_pkg::t_stat i_stat,
    output btha_pkg::t_cmd  o_cmd
);
    import btha_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_ok, n_ok;

    always_comb begin
        n_state = r_state;
        n_ok    = r_ok;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.mode == MODE_ALLOC) begin
                    if (i_stat.req_bad) begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end else begin
                    if (i_stat.blk_bad) begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.free_init = 1'b1;
                        n_state         = S_FREE_RD;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = S_MARK;
                end else if (i_stat.scan_end) begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                o_cmd.mark_step = 1'b1;
                if (i_stat.mark_last) begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_FREE_RD: begin
                o_cmd.free_rd = 1'b1;
                n_state       = S_FREE_WR;
            end
            S_FREE_WR: begin
                o_cmd.free_wr = 1'b1;
                if (i_stat.free_more) begin
                    n_state = S_FREE_RD;
                end else begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.put    = 1'b1;
                    o_cmd.put_ok = r_ok;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

[sv/block_table_heap_allocator.sv]
// Allocate: accept, check, first-fit scan of the table, marking of the run it finds (each
// one entry a cycle), result. Free: accept, check, then per entry of the run a RAM read and a
// write back that clears it, then the result. A request rejected at the check, or an allocate
// whose scan of the blocks in use finds no room, goes on to the result. One request at a time;
// the next is taken while the last result waits in its register. Reset (sync, active low) sets
// base 0 and block_count 1024, then clears the table RAM; no request is taken until it ends.
module block_table_heap_allocator #(
    parameter int BLOCK_BYTES = btha_pkg::BLOCK_BYTES_DEF, // power of two, 16 to 1M
    parameter int TABLE_DEPTH = btha_pkg::TABLE_DEPTH_DEF  // 2 to 65536 entries
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port: index 0 base_address, index 1 block_count
    input  logic                           i_cfg_we,
    input  logic [btha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [btha_pkg::CFG_W-1:0]     i_cfg_data,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [63:0]                    s_axis_tdata,  // [31:0] request_bytes, [63:32] free_address
    input  logic                           s_axis_tuser,  // [0] mode: 0 allocate, 1 free
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // [31:0] result_address
    output logic                           m_axis_tuser   // [0] success
);
    import btha_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: clear pass, request check, scan/mark or read/clear loop, result hand-off.
    btha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Table RAM, config registers, first-fit run counter and result register.
    btha_dp #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule
